>>> hw/rtl/mbb_pkg.sv
// Package for the one-bit-per-pixel framebuffer blitter.
// Holds request kind codes, register indexes and reset values, the read address width and the sequencer state type.
// No dependencies.
package mbb_pkg;

   // Request kinds carried on the request channel.
   typedef enum logic [1:0] {
      KIND_SET_PIXEL   = 2'd0,
      KIND_BEGIN_BLIT  = 2'd1,
      KIND_SOURCE_BYTE = 2'd2,
      KIND_READ_BYTE   = 2'd3
   } kind_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_FRAME_WIDTH      = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT     = 3'd1;
   localparam logic [2:0] CSR_BLIT_LEFT        = 3'd2;
   localparam logic [2:0] CSR_BLIT_TOP         = 3'd3;
   localparam logic [2:0] CSR_BLIT_COLUMNS     = 3'd4;
   localparam logic [2:0] CSR_BLIT_ROWS        = 3'd5;
   localparam logic [2:0] CSR_TRANSPARENT_MODE = 3'd6;

   // Register reset values.
   localparam logic [9:0] RST_FRAME_WIDTH  = 10'd256;
   localparam logic [8:0] RST_FRAME_HEIGHT = 9'd256;
   localparam logic [9:0] RST_BLIT_COLUMNS = 10'd8;
   localparam logic [8:0] RST_BLIT_ROWS    = 9'd8;

   // Width of the read address field.
   localparam int READ_ADDR_W = 14;

   // Sequencer states.
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PREP  = 8'b0000_0010,
      S_ADDR  = 8'b0000_0100,
      S_MOD   = 8'b0000_1000,
      S_RD    = 8'b0001_0000,
      S_WR    = 8'b0010_0000,
      S_RDATA = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

endpackage

>>> hw/rtl/mono_bitmap_blitter_unit.sv
// Top level of the one-bit-per-pixel framebuffer blitter.
// Depends on mbb_pkg and on the generic RAM mbb_ram.
//
// Usage: the request channel (req_valid / req_stall) carries one command per
// transfer: set a pixel, begin a blit, supply one source bitmap byte, or read
// a framebuffer byte. Every request transfer yields exactly one response
// transfer on the rsp_ channel, in order. The csr_ channel writes the frame
// and blit registers; it is always ready and must only be used while the
// block has no request in flight.
// Sequencing: the block takes one request at a time. A begin blit or stray
// source byte goes straight to its response; a read does one memory read; a
// set pixel or source byte does a read-modify-write per framebuffer byte it
// touches, two when a source byte spans two framebuffer bytes, and skips the
// memory when it draws nothing inside the frame. A frame or read address may
// also need modulo reduction steps (none with the default parameters). The
// work is set by the read-modify-write of the single frame memory port, one
// framebuffer byte at a time. The response is registered from the emit state.
// Reset (synchronous, active high) returns the registers to their defaults,
// ends any blit and empties the response register; the frame memory is not
// cleared and must be written before it is read. A stalled response holds
// in its output register; a new request is still taken, and its result
// waits in the sequencer until the response register frees up.
module mono_bitmap_blitter_unit
   import mbb_pkg::*;
#(
   parameter int FRAME_BYTES      = 16384,
   parameter int MAX_FRAME_WIDTH  = 512,
   parameter int MAX_FRAME_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [8:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic        req_pixel_value,
   input  logic [7:0]  req_source_byte,
   input  logic [13:0] req_read_address,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_clipped,
   output logic        rsp_blit_done,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);

   // Frame limits as seen through the register widths.
   localparam int MW_LIM = (MAX_FRAME_WIDTH < 1023) ? MAX_FRAME_WIDTH : 1023;
   localparam int MH_LIM = (MAX_FRAME_HEIGHT < 511) ? MAX_FRAME_HEIGHT : 511;
   localparam logic [9:0] MW_CLAMP = 10'(MW_LIM);
   localparam logic [8:0] MH_CLAMP = 9'(MH_LIM);
   // Exclusive bound of a linear frame address and the width that holds it.
   localparam int LIN_MAX = MH_LIM * (MW_LIM / 8);
   localparam int LIN_W   = (LIN_MAX > 1) ? $clog2(LIN_MAX) : 1;
   localparam int RED_W   = (LIN_W > READ_ADDR_W) ? LIN_W : READ_ADDR_W;
   // Memory address width, as the RAM derives it.
   localparam int ADDR_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   // Restoring reduction modulo FRAME_BYTES: one compare and subtract of
   // FRAME_BYTES shifted by k per step, k counting down to zero.
   localparam int FLO       = $clog2(FRAME_BYTES + 1) - 1;
   localparam int MOD_STEPS = (RED_W > FLO) ? (RED_W - FLO) : 0;
   localparam int MOD_LAST  = (MOD_STEPS > 0) ? (MOD_STEPS - 1) : 0;
   localparam int MK_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam bit HAS_MOD   = (MOD_STEPS > 0);
   localparam logic [RED_W-1:0] FRAME_BYTES_R = RED_W'(FRAME_BYTES);

   // Configuration registers.
   logic [9:0] csr_frame_width_ff;
   logic [8:0] csr_frame_height_ff;
   logic [8:0] csr_blit_left_ff;
   logic [7:0] csr_blit_top_ff;
   logic [9:0] csr_blit_columns_ff;
   logic [8:0] csr_blit_rows_ff;
   logic       csr_transparent_ff;

   // Sequencer and blit progress.
   state_type  state_ff, state_in;
   logic [6:0] col_ff, col_in;
   logic [8:0] line_ff, line_in;
   logic       blit_on_ff, blit_on_in;

   // Work registers of the current request.
   kind_type         kind_ff, kind_in;
   logic [10:0]      job_x_ff, job_x_in;
   logic [9:0]       job_y_ff, job_y_in;
   logic [7:0]       lane_en_ff, lane_en_in;
   logic [7:0]       lane_val_ff, lane_val_in;
   logic [15:0]      mask_ff, mask_in;
   logic [15:0]      wdata_ff, wdata_in;
   logic [15:0]      prod_ff, prod_in;
   logic [6:0]       xb_ff, xb_in;
   logic             half_ff, half_in;
   logic [RED_W-1:0] red_ff, red_in;
   logic [MK_W-1:0]  mod_k_ff, mod_k_in;
   logic [7:0]       res_data_ff, res_data_in;
   logic             res_clip_ff, res_clip_in;
   logic             res_done_ff, res_done_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_clipped_ff, rsp_clipped_in;
   logic       rsp_blit_done_ff, rsp_blit_done_in;

   // Frame memory port.
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wr_data;
   logic [7:0]        ram_rd_data;

   // Effective frame size.
   logic [9:0] eff_w;
   logic [8:0] eff_h;
   logic [9:0] w_clamped;

   assign w_clamped = (csr_frame_width_ff > MW_CLAMP) ? MW_CLAMP : csr_frame_width_ff;
   assign eff_w     = {w_clamped[9:3], 3'b000};
   assign eff_h     = (csr_frame_height_ff > MH_CLAMP) ? MH_CLAMP : csr_frame_height_ff;

   // Blit fit test for a begin-blit request.
   logic [10:0] fit_x_end;
   logic [9:0]  fit_y_end;
   logic        fit_clip;

   assign fit_x_end = 11'(csr_blit_left_ff) + 11'(csr_blit_columns_ff);
   assign fit_y_end = 10'(csr_blit_top_ff) + 10'(csr_blit_rows_ff);
   assign fit_clip  = (csr_blit_columns_ff == 10'd0) || (csr_blit_rows_ff == 9'd0) ||
                      (fit_x_end > 11'(eff_w)) || (fit_y_end > 10'(eff_h));

   // Source byte placement and row bookkeeping.
   logic [7:0]  per_line;
   logic [7:0]  col_next;
   logic [9:0]  line_next;
   logic        row_end;
   logic        blit_end;
   logic [10:0] src_x0;
   logic [9:0]  src_y;
   logic [9:0]  src_j [8];
   logic [7:0]  src_en;
   logic [7:0]  src_val;

   assign per_line  = 8'((11'(csr_blit_columns_ff) + 11'd7) >> 3);
   assign col_next  = {1'b0, col_ff} + 8'd1;
   assign row_end   = (col_next >= per_line);
   assign line_next = {1'b0, line_ff} + 10'd1;
   assign blit_end  = (line_next >= {1'b0, csr_blit_rows_ff});
   assign src_x0    = 11'(csr_blit_left_ff) + 11'({col_ff, 3'b000});
   assign src_y     = 10'(csr_blit_top_ff) + 10'(line_ff);

   // The MSB of a source byte is its leftmost pixel, lane 0.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         src_j[b]   = {col_ff, 3'b000} + 10'(b);
         src_val[b] = req_source_byte[7-b];
         src_en[b]  = (src_j[b] < csr_blit_columns_ff) &&
                      (src_val[b] || !csr_transparent_ff);
      end
   end

   // Per-lane frame test of the captured job.
   logic [11:0] lane_x [8];
   logic [7:0]  lane_ok;
   logic        job_y_ok;

   assign job_y_ok = (job_y_ff < {1'b0, eff_h});

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         lane_x[b]  = {1'b0, job_x_ff} + 12'(b);
         lane_ok[b] = lane_en_ff[b] && job_y_ok && (lane_x[b] < {2'b00, eff_w});
      end
   end

   // Shared address and merge datapath.
   logic             sel_hi;
   logic             half_active;
   logic [16:0]      lin_sum;
   logic [RED_W-1:0] mod_sub;
   logic [7:0]       byte_mask;
   logic [7:0]       byte_data;
   logic             out_free;
   kind_type         req_kind_t;

   assign sel_hi      = half_ff || (mask_ff[7:0] == 8'd0);
   assign half_active = sel_hi ? (mask_ff[15:8] != 8'd0) : 1'b1;
   assign lin_sum     = 17'(prod_ff) + 17'(xb_ff) + 17'(sel_hi);
   assign mod_sub     = FRAME_BYTES_R << mod_k_ff;
   assign byte_mask   = half_ff ? mask_ff[15:8] : mask_ff[7:0];
   assign byte_data   = half_ff ? wdata_ff[15:8] : wdata_ff[7:0];
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_kind_t  = kind_type'(req_kind);
   assign ram_addr    = ADDR_W'(red_ff);
   assign ram_wr_data = (ram_rd_data & ~byte_mask) | (byte_data & byte_mask);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      line_in     = line_ff;
      blit_on_in  = blit_on_ff;
      kind_in     = kind_ff;
      job_x_in    = job_x_ff;
      job_y_in    = job_y_ff;
      lane_en_in  = lane_en_ff;
      lane_val_in = lane_val_ff;
      mask_in     = mask_ff;
      wdata_in    = wdata_ff;
      prod_in     = prod_ff;
      xb_in       = xb_ff;
      half_in     = half_ff;
      red_in      = red_ff;
      mod_k_in    = mod_k_ff;
      res_data_in = res_data_ff;
      res_clip_in = res_clip_ff;
      res_done_in = res_done_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_clipped_in   = rsp_clipped_ff;
      rsp_blit_done_in = rsp_blit_done_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in     = req_kind_t;
               res_data_in = 8'd0;
               res_clip_in = 1'b0;
               res_done_in = 1'b0;
               mod_k_in    = MK_W'(MOD_LAST);
               unique case (req_kind_t)
                  KIND_SET_PIXEL: begin
                     job_x_in    = 11'(req_pixel_x);
                     job_y_in    = 10'(req_pixel_y);
                     lane_en_in  = 8'b0000_0001;
                     lane_val_in = {7'd0, req_pixel_value};
                     state_in    = S_PREP;
                  end
                  KIND_BEGIN_BLIT: begin
                     col_in      = 7'd0;
                     line_in     = 9'd0;
                     blit_on_in  = !fit_clip;
                     res_clip_in = fit_clip;
                     state_in    = S_EMIT;
                  end
                  KIND_SOURCE_BYTE: begin
                     if (blit_on_ff) begin
                        job_x_in    = src_x0;
                        job_y_in    = src_y;
                        lane_en_in  = src_en;
                        lane_val_in = src_val;
                        state_in    = S_PREP;
                        if (row_end) begin
                           col_in = 7'd0;
                           if (blit_end) begin
                              line_in     = 9'd0;
                              blit_on_in  = 1'b0;
                              res_done_in = 1'b1;
                           end else begin
                              line_in = line_next[8:0];
                           end
                        end else begin
                           col_in = col_next[6:0];
                        end
                     end else begin
                        // A source byte with no blit in progress is dropped.
                        state_in = S_EMIT;
                     end
                  end
                  KIND_READ_BYTE: begin
                     red_in   = RED_W'(req_read_address);
                     state_in = HAS_MOD ? S_MOD : S_RD;
                  end
               endcase
            end
         end
         S_PREP: begin
            // Lane b lands at bit (x mod 8) + b of a two-byte window.
            mask_in  = {8'h00, lane_ok} << job_x_ff[2:0];
            wdata_in = {8'h00, lane_val_ff} << job_x_ff[2:0];
            prod_in  = 16'(job_y_ff[8:0]) * 16'(eff_w[9:3]);
            xb_in    = job_x_ff[9:3];
            half_in  = 1'b0;
            if (kind_ff == KIND_SET_PIXEL) begin
               res_clip_in = !lane_ok[0];
            end
            state_in = S_ADDR;
         end
         S_ADDR: begin
            mod_k_in = MK_W'(MOD_LAST);
            if (half_active) begin
               half_in  = sel_hi;
               red_in   = RED_W'(lin_sum);
               state_in = HAS_MOD ? S_MOD : S_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_MOD: begin
            if (red_ff >= mod_sub) begin
               red_in = red_ff - mod_sub;
            end
            if (mod_k_ff == MK_W'(0)) begin
               state_in = S_RD;
            end else begin
               mod_k_in = mod_k_ff - MK_W'(1);
            end
         end
         S_RD: begin
            ram_rd_en = 1'b1;
            state_in  = (kind_ff == KIND_READ_BYTE) ? S_RDATA : S_WR;
         end
         S_WR: begin
            ram_wr_en = 1'b1;
            if (!half_ff && (mask_ff[15:8] != 8'd0)) begin
               half_in  = 1'b1;
               state_in = S_ADDR;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_RDATA: begin
            res_data_in = ram_rd_data;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = res_data_ff;
               rsp_clipped_in   = res_clip_ff;
               rsp_blit_done_in = res_done_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         col_ff              <= 7'd0;
         line_ff             <= 9'd0;
         blit_on_ff          <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         csr_frame_width_ff  <= RST_FRAME_WIDTH;
         csr_frame_height_ff <= RST_FRAME_HEIGHT;
         csr_blit_left_ff    <= 9'd0;
         csr_blit_top_ff     <= 8'd0;
         csr_blit_columns_ff <= RST_BLIT_COLUMNS;
         csr_blit_rows_ff    <= RST_BLIT_ROWS;
         csr_transparent_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         blit_on_ff   <= blit_on_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:      csr_frame_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT:     csr_frame_height_ff <= csr_data[8:0];
               CSR_BLIT_LEFT:        csr_blit_left_ff    <= csr_data[8:0];
               CSR_BLIT_TOP:         csr_blit_top_ff     <= csr_data[7:0];
               CSR_BLIT_COLUMNS:     csr_blit_columns_ff <= csr_data;
               CSR_BLIT_ROWS:        csr_blit_rows_ff    <= csr_data[8:0];
               CSR_TRANSPARENT_MODE: csr_transparent_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      job_x_ff         <= job_x_in;
      job_y_ff         <= job_y_in;
      lane_en_ff       <= lane_en_in;
      lane_val_ff      <= lane_val_in;
      mask_ff          <= mask_in;
      wdata_ff         <= wdata_in;
      prod_ff          <= prod_in;
      xb_ff            <= xb_in;
      half_ff          <= half_in;
      red_ff           <= red_in;
      mod_k_ff         <= mod_k_in;
      res_data_ff      <= res_data_in;
      res_clip_ff      <= res_clip_in;
      res_done_ff      <= res_done_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_clipped_ff   <= rsp_clipped_in;
      rsp_blit_done_ff <= rsp_blit_done_in;
   end

   // Frame memory.
   mbb_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_BYTES)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_addr),
      .rd_data(ram_rd_data)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_clipped   = rsp_clipped_ff;
   assign rsp_blit_done = rsp_blit_done_ff;

endmodule

>>> hw/rtl/mbb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module mbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
